FILE: hw/rtl/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg
// Shared types and constants for the multiplexed one-shot timer block.
// ----------------------------------------------------------------------------
package mot_pkg;

  // Slot bank size and the width of the scan index over it
  localparam int unsigned SLOTS = 8;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned US_W     = 16;
  localparam int unsigned EL_W     = 16;
  localparam int unsigned CPU_W    = 8;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned REM_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 2'd2;

  // Configuration reset values
  localparam logic [CPU_W-1:0] CYCLES_PER_US_RST = 8'd6;
  localparam logic [CNT_W-1:0] MIN_COUNT_RST     = 16'd20;
  localparam logic [CNT_W-1:0] MAX_COUNT_RST     = 16'hFF00;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_SUM
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input word
    logic apply;     // run start or stop, open the scan
    logic step;      // process one slot of the scan
    logic load_sum;  // load the schedule summary into the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fire_req;  // the slot under scan expires in this step
    logic last_idx;  // the scan is at the final slot
    logic out_free;  // the output register can take a word this cycle
  } dp_status_t;

endpackage

FILE: hw/rtl/mot_ctrl.sv
// ----------------------------------------------------------------------------
// mot_ctrl
// Sequencer: takes an input word, applies it, scans the slots one per cycle
// while no fired slot waits on the output, and issues the schedule summary.
// ----------------------------------------------------------------------------
module mot_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mot_pkg::dp_status_t status_i,
  output mot_pkg::ctrl_cmd_t  cmd_o
);
  import mot_pkg::*;

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_SCAN;
      ST_SCAN: begin
        if ((!status_i.fire_req || status_i.out_free) && status_i.last_idx) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_APPLY: cmd_o.apply = 1'b1;
      ST_SCAN:  cmd_o.step  = !status_i.fire_req || status_i.out_free;
      ST_SUM:   cmd_o.load_sum = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/mot_dp.sv
// ----------------------------------------------------------------------------
// mot_dp
// Datapath: configuration registers, slot bank, scan unit with running
// minimum, and the output register.
// ----------------------------------------------------------------------------
module mot_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mot_pkg::ctrl_cmd_t                  cmd_i,
  output mot_pkg::dp_status_t                 status_o,
  // input word
  input  logic [mot_pkg::CMD_W-1:0]           cmd_in_i,
  input  logic [mot_pkg::SLOT_W-1:0]          slot_i,
  input  logic [mot_pkg::ID_W-1:0]            handler_id_i,
  input  logic [mot_pkg::US_W-1:0]            interval_us_i,
  input  logic [mot_pkg::EL_W-1:0]            elapsed_cycles_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [mot_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mot_pkg::CNT_W-1:0]           cfg_data_i,
  // result word
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [mot_pkg::SLOT_W-1:0]          fired_slot_o,
  output logic [mot_pkg::ID_W-1:0]            fired_id_o,
  output logic [mot_pkg::CNT_W-1:0]           next_target_o,
  output logic                                running_o,
  output logic                                last_o
);
  import mot_pkg::*;

  // Configuration
  logic [CPU_W-1:0] cpu_q;
  logic [CNT_W-1:0] min_q, max_q;

  // Captured input word
  logic [CMD_W-1:0]  op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ID_W-1:0]   hid_q;
  logic [US_W-1:0]   ius_q;
  logic [EL_W-1:0]   el_q;

  // Slot bank
  logic [SLOTS-1:0]  active_q;
  logic [REM_W-1:0]  rem_q [SLOTS];
  logic [ID_W-1:0]   id_q  [SLOTS];

  // Scan state
  logic [IDX_W-1:0]  idx_q;
  logic              any_q;
  logic [REM_W-1:0]  least_q;

  // Output register
  logic              out_valid_q;
  logic              kind_q;
  logic [SLOT_W-1:0] fslot_q;
  logic [ID_W-1:0]   fid_q;
  logic [CNT_W-1:0]  target_q;
  logic              run_q;
  logic              last_q;

  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [REM_W-1:0]  product;
  logic              is_tick;
  logic [REM_W-1:0]  rem_cur;
  logic [REM_W-1:0]  el_ext;
  logic [REM_W-1:0]  rem_new;
  logic              fire;
  logic              out_free;
  logic [REM_W-1:0]  min_ext, max_ext;
  logic [REM_W-1:0]  clamped;
  logic [CNT_W-1:0]  target;

  // Decode the captured word
  assign slot_ok  = 32'(slot_q) < SLOTS;
  assign slot_idx = IDX_W'(slot_q);
  assign product  = REM_W'(ius_q) * REM_W'(cpu_q);
  assign is_tick  = (op_q == CMD_TICK);

  // Age the slot under scan, floored at zero
  assign rem_cur = rem_q[idx_q];
  assign el_ext  = REM_W'(el_q);
  assign rem_new = !is_tick ? rem_cur : ((rem_cur > el_ext) ? rem_cur - el_ext : '0);
  assign min_ext = REM_W'(min_q);
  assign max_ext = REM_W'(max_q);
  assign fire    = is_tick && active_q[idx_q] && (rem_new <= min_ext);

  // Clamp the least remaining count; the lower clamp wins
  always_comb begin
    clamped = least_q;
    if (clamped > max_ext) clamped = max_ext;
    if (clamped < min_ext) clamped = min_ext;
    target = any_q ? CNT_W'(clamped) : '0;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.fire_req = fire;
  assign status_o.last_idx = (32'(idx_q) == SLOTS - 1);
  assign status_o.out_free = out_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= CYCLES_PER_US_RST;
      min_q <= MIN_COUNT_RST;
      max_q <= MAX_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CYCLES_PER_US: cpu_q <= cfg_data_i[CPU_W-1:0];
        REG_MIN_COUNT:     min_q <= cfg_data_i;
        REG_MAX_COUNT:     max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= cmd_in_i;
      slot_q <= slot_i;
      hid_q  <= handler_id_i;
      ius_q  <= interval_us_i;
      el_q   <= elapsed_cycles_i;
    end
  end

  // Track active slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.apply && slot_ok) begin
      if (op_q == CMD_START) active_q[slot_idx] <= 1'b1;
      if (op_q == CMD_STOP)  active_q[slot_idx] <= 1'b0;
    end else if (cmd_i.step && fire) begin
      active_q[idx_q] <= 1'b0;
    end
  end

  // Load or age slot counts and ids
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && slot_ok && (op_q == CMD_START)) begin
      rem_q[slot_idx] <= product;
      id_q[slot_idx]  <= hid_q;
    end else if (cmd_i.step && is_tick && active_q[idx_q]) begin
      rem_q[idx_q] <= rem_new;
    end
  end

  // Walk the slots and keep the least remaining count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      any_q   <= 1'b0;
      least_q <= '1;
    end else if (cmd_i.apply) begin
      idx_q   <= '0;
      any_q   <= 1'b0;
      least_q <= '1;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (active_q[idx_q] && !fire) begin
        any_q <= 1'b1;
        if (rem_new < least_q) least_q <= rem_new;
      end
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.step && fire) || cmd_i.load_sum) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && fire) begin
      kind_q   <= KIND_FIRE;
      fslot_q  <= SLOT_W'(idx_q);
      fid_q    <= id_q[idx_q];
      target_q <= '0;
      run_q    <= 1'b0;
      last_q   <= 1'b0;
    end else if (cmd_i.load_sum) begin
      kind_q   <= KIND_SUMMARY;
      fslot_q  <= '0;
      fid_q    <= '0;
      target_q <= target;
      run_q    <= any_q;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign fired_slot_o  = fslot_q;
  assign fired_id_o    = fid_q;
  assign next_target_o = target_q;
  assign running_o     = run_q;
  assign last_o        = last_q;

endmodule

FILE: hw/rtl/multiplexed_oneshot_timers.sv
// ----------------------------------------------------------------------------
// multiplexed_oneshot_timers
// Bank of one-shot timer slots sharing one compare counter.
// ----------------------------------------------------------------------------
// Each input word (start, stop or tick) is handled in steps: the word is taken,
// the addressed slot is loaded or freed, the scan visits each slot, ageing the
// slots on a tick, reporting expired ones in ascending order and tracking the
// least remaining count, and the schedule summary is issued, which is always
// the last word out. The scan visits one slot per cycle while it is not held;
// a fired slot waits while the output stalls, as does the summary. The next
// input word is taken while the summary still waits in the output register.
// Configuration writes are always ready and must come only while the block
// is idle.
// ----------------------------------------------------------------------------
module multiplexed_oneshot_timers (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mot_pkg::CMD_W-1:0]        cmd_i,
  input  logic [mot_pkg::SLOT_W-1:0]       slot_i,
  input  logic [mot_pkg::ID_W-1:0]         handler_id_i,
  input  logic [mot_pkg::US_W-1:0]         interval_us_i,
  input  logic [mot_pkg::EL_W-1:0]         elapsed_cycles_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [mot_pkg::SLOT_W-1:0]       fired_slot_o,
  output logic [mot_pkg::ID_W-1:0]         fired_id_o,
  output logic [mot_pkg::CNT_W-1:0]        next_target_o,
  output logic                             running_o,
  output logic                             last_o,
  // configuration channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mot_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mot_pkg::CNT_W-1:0]        cfg_data_i
);
  import mot_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  mot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath
  mot_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .cmd_in_i         (cmd_i),
    .slot_i           (slot_i),
    .handler_id_i     (handler_id_i),
    .interval_us_i    (interval_us_i),
    .elapsed_cycles_i (elapsed_cycles_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .fired_slot_o     (fired_slot_o),
    .fired_id_o       (fired_id_o),
    .next_target_o    (next_target_o),
    .running_o        (running_o),
    .last_o           (last_o)
  );

endmodule
